FILE: sv/box_surface_inside_and_ray_distance_unit_macros.svh
// Assertion macros shared by the box inside and ray distance design.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef BOX_SURFACE_INSIDE_AND_RAY_DISTANCE_UNIT_MACROS_SVH
`define BOX_SURFACE_INSIDE_AND_RAY_DISTANCE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BSIR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define BSIR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define BSIR_ASSERT_IMP(label, ante, cons)
`define BSIR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: sv/bsir_pkg.sv
`timescale 1ns / 1ps

package bsir_pkg;

	// Field widths.
	localparam int CoordW    = 32;
	localparam int DirW      = 32;
	localparam int DistW     = 32;
	localparam int MagW      = CoordW + 1;
	localparam int NumAxes   = 3;
	localparam int NumPlanes = 2 * NumAxes;
	localparam int DivSteps  = DistW;
	localparam int CfgIdxW   = 3;

	// Stream payload widths, padded to whole bytes.
	localparam int InFieldsW  = NumAxes * CoordW + NumAxes * DirW;
	localparam int InDataW    = ((InFieldsW + 7) / 8) * 8;
	localparam int OutFieldsW = 2 + DistW;
	localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;

	// Register indexes on the configuration port.
	localparam logic [CfgIdxW-1:0] RegXLow  = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] RegXHigh = CfgIdxW'(1);
	localparam logic [CfgIdxW-1:0] RegYLow  = CfgIdxW'(2);
	localparam logic [CfgIdxW-1:0] RegYHigh = CfgIdxW'(3);
	localparam logic [CfgIdxW-1:0] RegZLow  = CfgIdxW'(4);
	localparam logic [CfgIdxW-1:0] RegZHigh = CfgIdxW'(5);

	// One plane's state while its distance is divided out bit by bit.
	typedef struct packed {
		logic             cand;
		logic             sat;
		logic [1:0]       nlo;
		logic [DirW-1:0]  den;
		logic [DirW-1:0]  rem;
		logic [DistW-1:0] quo;
	} div_t;

endpackage

FILE: sv/box_surface_inside_and_ray_distance_unit.sv
`timescale 1ns / 1ps
`include "box_surface_inside_and_ray_distance_unit_macros.svh"

// Box inside test and distance to the nearest plane ahead.
//
// Input stream s_*: one item is a point (Q16.16) and a direction (Q2.30).
// Output stream m_*: one item per input item, in order: the inside flag, the
// hit flag and the nearest strictly positive plane distance (Q16.16, zero
// when nothing is hit, saturated at all ones).
// Configuration port cfg_*: six box planes, written by index; always ready.
// Write it only while no item is in flight.
//
// From input acceptance to the result being offered, an item passes through
// one input stage, one plane set-up stage, 32 restoring divider stages (one
// quotient bit each, six planes side by side) and two stages of minimum.
// An item can be taken every cycle. When the receiver stalls with a result
// waiting, the whole pipeline holds and s_tready drops; nothing is lost.
// Reset empties the pipeline and clears all box planes to zero.
module box_surface_inside_and_ray_distance_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// pos_x, pos_y, pos_z, dir_u, dir_v, dir_w from bit 0 up
	input  logic [bsir_pkg::InDataW-1:0]   s_tdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// inside_res, hit, distance from bit 0 up, zero padded
	output logic [bsir_pkg::OutDataW-1:0]  m_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bsir_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [bsir_pkg::CoordW-1:0]    cfg_data
);

	localparam int CW = bsir_pkg::CoordW;
	localparam int DW = bsir_pkg::DirW;
	localparam int MW = bsir_pkg::MagW;
	localparam int QW = bsir_pkg::DistW;
	localparam int NA = bsir_pkg::NumAxes;
	localparam int NP = bsir_pkg::NumPlanes;
	localparam int NS = bsir_pkg::DivSteps;
	localparam int SW = (MW > DW + 2) ? MW : DW + 2;

	// Box planes.
	logic signed [CW-1:0] box_q [0:NP-1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NP; i++) begin
				box_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				bsir_pkg::RegXLow:  box_q[0] <= cfg_data;
				bsir_pkg::RegXHigh: box_q[1] <= cfg_data;
				bsir_pkg::RegYLow:  box_q[2] <= cfg_data;
				bsir_pkg::RegYHigh: box_q[3] <= cfg_data;
				bsir_pkg::RegZLow:  box_q[4] <= cfg_data;
				bsir_pkg::RegZHigh: box_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Whole-pipeline advance: hold only when a result waits on a stalled receiver.
	logic adv;
	logic v_s4;

	assign adv      = !v_s4 || m_tready;
	assign s_tready = adv;

	// Stage 1: capture the item.
	logic                 v_s1;
	logic signed [CW-1:0] pos_s1 [0:NA-1];
	logic signed [DW-1:0] dir_s1 [0:NA-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < NA; a++) begin
				pos_s1[a] <= s_tdata[a*CW +: CW];
				dir_s1[a] <= s_tdata[NA*CW + a*DW +: DW];
			end
		end
	end

	// Plane set-up: sign checks, magnitudes, saturation and the inside test.
	bsir_pkg::div_t plane_nx [0:NP-1];
	logic           inside_nx;

	always_comb begin
		logic signed [MW-1:0] diff;
		logic [MW-1:0]        mag;
		logic [DW-1:0]        den;
		logic [MW+QW-1:0]     shifted;
		logic                 num_neg;
		logic                 dir_neg;
		logic signed [CW-1:0] q;
		logic signed [CW-1:0] p;
		logic signed [DW-1:0] d;
		inside_nx = 1'b1;
		for (int i = 0; i < NP; i++) begin
			q       = box_q[i];
			p       = pos_s1[i/2];
			d       = dir_s1[i/2];
			diff    = MW'(q) - MW'(p);
			num_neg = diff[MW-1];
			dir_neg = d[DW-1];
			mag     = num_neg ? MW'(-diff) : MW'(diff);
			den     = dir_neg ? DW'(-d) : DW'(d);
			shifted = (MW+QW)'(mag) >> 2;
			plane_nx[i].cand = (d != '0) && (diff != '0) && (num_neg == dir_neg);
			plane_nx[i].sat  = SW'(mag) >= (SW'(den) << 2);
			plane_nx[i].nlo  = mag[1:0];
			plane_nx[i].den  = den;
			plane_nx[i].rem  = shifted[DW-1:0];
			plane_nx[i].quo  = '0;
		end
		for (int a = 0; a < NA; a++) begin
			if (pos_s1[a] < box_q[2*a] || box_q[2*a+1] < pos_s1[a]) begin
				inside_nx = 1'b0;
			end
		end
	end

	// Divider pipeline: entry 0 is the set-up stage, entry k after k quotient bits.
	logic           div_v_s      [0:NS];
	logic           div_inside_s [0:NS];
	bsir_pkg::div_t div_s        [0:NS][0:NP-1];
	bsir_pkg::div_t div_nx       [0:NS-1][0:NP-1];

	always_comb begin
		logic [DW:0] r2;
		logic        nb;
		for (int k = 0; k < NS; k++) begin
			for (int i = 0; i < NP; i++) begin
				div_nx[k][i] = div_s[k][i];
				case (k)
					0:       nb = div_s[k][i].nlo[1];
					1:       nb = div_s[k][i].nlo[0];
					default: nb = 1'b0;
				endcase
				r2 = {div_s[k][i].rem, nb};
				if (r2 >= {1'b0, div_s[k][i].den}) begin
					r2                = r2 - {1'b0, div_s[k][i].den};
					div_nx[k][i].quo = {div_s[k][i].quo[QW-2:0], 1'b1};
				end else begin
					div_nx[k][i].quo = {div_s[k][i].quo[QW-2:0], 1'b0};
				end
				div_nx[k][i].rem = r2[DW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NS; k++) begin
				div_v_s[k] <= 1'b0;
			end
		end else if (adv) begin
			div_v_s[0] <= v_s1;
			for (int k = 0; k < NS; k++) begin
				div_v_s[k+1] <= div_v_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_inside_s[0] <= inside_nx;
			for (int i = 0; i < NP; i++) begin
				div_s[0][i] <= plane_nx[i];
			end
			for (int k = 0; k < NS; k++) begin
				div_inside_s[k+1] <= div_inside_s[k];
				for (int i = 0; i < NP; i++) begin
					div_s[k+1][i] <= div_nx[k][i];
				end
			end
		end
	end

	// Stage 3: final distances and the minimum of each axis pair.
	logic          v_s3;
	logic          inside_s3;
	logic          ok_s3   [0:NA-1];
	logic [QW-1:0] dist_s3 [0:NA-1];
	logic          ok_nx   [0:NP-1];
	logic [QW-1:0] dist_nx [0:NP-1];

	always_comb begin
		for (int i = 0; i < NP; i++) begin
			dist_nx[i] = div_s[NS][i].sat ? '1 : div_s[NS][i].quo;
			ok_nx[i]   = div_s[NS][i].cand && (dist_nx[i] != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= div_v_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inside_s3 <= div_inside_s[NS];
			for (int a = 0; a < NA; a++) begin
				ok_s3[a] <= ok_nx[2*a] || ok_nx[2*a+1];
				if (ok_nx[2*a] && (!ok_nx[2*a+1] || dist_nx[2*a] <= dist_nx[2*a+1])) begin
					dist_s3[a] <= dist_nx[2*a];
				end else begin
					dist_s3[a] <= dist_nx[2*a+1];
				end
			end
		end
	end

	// Stage 4: minimum over the three axes, held as the output register.
	logic          inside_s4;
	logic          hit_s4;
	logic [QW-1:0] dist_s4;

	always_comb begin
		m_tdata           = '0;
		m_tdata[0]        = inside_s4;
		m_tdata[1]        = hit_s4;
		m_tdata[2 +: QW]  = dist_s4;
	end
	assign m_tvalid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		logic          bok;
		logic [QW-1:0] bd;
		if (adv) begin
			bok = ok_s3[0];
			bd  = dist_s3[0];
			for (int a = 1; a < NA; a++) begin
				if (ok_s3[a] && (!bok || dist_s3[a] < bd)) begin
					bd  = dist_s3[a];
					bok = 1'b1;
				end
			end
			inside_s4 <= inside_s3;
			hit_s4    <= bok;
			dist_s4   <= bok ? bd : '0;
		end
	end

	// Checks.
	`BSIR_ASSERT_IMP(a_nohit_zero, m_tvalid && !m_tdata[1], m_tdata[2 +: QW] == '0)
	`BSIR_ASSERT_IMP(a_ready_empty, !m_tvalid, s_tready)
	`BSIR_ASSERT_NEXT(a_stall_hold, !adv, $stable(v_s3) && $stable(div_v_s[NS]))

endmodule

FILE: dv/box_surface_inside_and_ray_distance_unit_tb.sv
`timescale 1ns / 1ps

module box_surface_inside_and_ray_distance_unit_tb;

	// Indexes beyond the six box planes; writes to them must be ignored.
	localparam logic [bsir_pkg::CfgIdxW-1:0] RegSpare6 = bsir_pkg::CfgIdxW'(6);
	localparam logic [bsir_pkg::CfgIdxW-1:0] RegSpare7 = bsir_pkg::CfgIdxW'(7);
	localparam logic [31:0] DistSat = 32'hFFFF_FFFF;
	localparam logic [31:0] DirOne  = 32'h4000_0000;
	localparam int StallLimit = 20000;
	localparam int DrainCycles = 60;

	typedef struct packed {
		logic [2:0][31:0] dir;
		logic [2:0][31:0] pos;
	} ray_t;

	typedef struct packed {
		logic [31:0] distance;
		logic        hit;
		logic        inside_flag;
	} slab_res_t;

	typedef struct packed {
		ray_t      ray;
		logic      typed;
		slab_res_t res;
	} ray_row_t;

	logic                              clk;
	logic                              arst_n;
	logic [bsir_pkg::InDataW-1:0]      s_tdata;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [bsir_pkg::OutDataW-1:0]     m_tdata;
	logic                              m_tvalid;
	logic                              m_tready;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [bsir_pkg::CfgIdxW-1:0]      cfg_index;
	logic [bsir_pkg::CoordW-1:0]       cfg_data;

	logic signed [31:0] box_plane [6];
	slab_res_t          pending_res [$];
	ray_row_t           ray_rows [$];
	int                 mismatches;
	bit                 no_idle;

	box_surface_inside_and_ray_distance_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Inside test and nearest plane ahead, worked out in 64-bit arithmetic.
	function automatic slab_res_t predict_slab(ray_t r);
		slab_res_t res;
		logic found;
		longint p, d, q;
		longint unsigned mag, den, plane_dist, best;
		res = '0;
		res.inside_flag = 1'b1;
		found = 1'b0;
		best = 0;
		for (int a = 0; a < 3; a++) begin
			p = longint'($signed(r.pos[a]));
			d = longint'($signed(r.dir[a]));
			if (p < longint'(box_plane[2*a]) || p > longint'(box_plane[2*a+1]))
				res.inside_flag = 1'b0;
			if (d != 0) begin
				for (int k = 0; k < 2; k++) begin
					q = longint'(box_plane[2*a+k]);
					if (q != p && ((q < p) == (d < 0))) begin
						mag = (q < p) ? p - q : q - p;
						den = (d < 0) ? -d : d;
						if (mag >= (den << 2))
							plane_dist = DistSat;
						else
							plane_dist = (mag << 30) / den;
						if (plane_dist != 0 && (!found || plane_dist < best)) begin
							best = plane_dist;
							found = 1'b1;
						end
					end
				end
			end
		end
		res.hit = found;
		res.distance = found ? best[31:0] : '0;
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Result side: random stalls, mostly short.
	initial begin
		int hold;
		m_tready = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				m_tready = 1'b0;
				hold--;
			end else begin
				m_tready = 1'b1;
				hold = pick_gap();
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		slab_res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[33:0];
			if (pending_res.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result item %h", got);
			end else begin
				want = pending_res.pop_front();
				if (got.inside_flag !== want.inside_flag || got.hit !== want.hit
						|| got.distance !== want.distance) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected inside %b hit %b distance %h, got %b %b %h",
							want.inside_flag, want.hit, want.distance,
							got.inside_flag, got.hit, got.distance);
				end
			end
		end
	end

	// Watchdog on cycles with no handshake anywhere.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= StallLimit) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic send_ray(ray_t r, logic typed, slab_res_t want);
		repeat (pick_gap()) @(negedge clk);
		s_tdata = '0;
		s_tdata[191:0] = r;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_res.push_back(typed ? want : predict_slab(r));
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	// Waits until every result is back and the pipeline has run dry.
	task automatic drain();
		while (pending_res.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(logic [bsir_pkg::CfgIdxW-1:0] idx, logic [31:0] value);
		cfg_index = idx;
		cfg_data = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx < 6)
			box_plane[idx] = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_box(logic [31:0] xl, logic [31:0] xh, logic [31:0] yl,
			logic [31:0] yh, logic [31:0] zl, logic [31:0] zh);
		drain();
		write_reg(bsir_pkg::RegXLow, xl);
		write_reg(bsir_pkg::RegXHigh, xh);
		write_reg(bsir_pkg::RegYLow, yl);
		write_reg(bsir_pkg::RegYHigh, yh);
		write_reg(bsir_pkg::RegZLow, zl);
		write_reg(bsir_pkg::RegZHigh, zh);
	endtask

	task automatic add_row(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [31:0] du, logic [31:0] dv, logic [31:0] dw,
			logic typed, logic exp_inside, logic hit, logic [31:0] exp_dist);
		ray_row_t row;
		row.ray.pos = {pz, py, px};
		row.ray.dir = {dw, dv, du};
		row.typed = typed;
		row.res.inside_flag = exp_inside;
		row.res.hit = hit;
		row.res.distance = exp_dist;
		ray_rows.push_back(row);
	endtask

	function automatic logic [31:0] rand_dir();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return $urandom();
			2: return $urandom_range(0, 1) ? DirOne : -DirOne;
			3: return $urandom_range(0, 1) ? $urandom_range(1, 255) : -$urandom_range(1, 255);
			default: return $urandom_range(0, 32'h8000_0000) - DirOne;
		endcase
	endfunction

	function automatic logic [31:0] rand_coord(logic [31:0] lo, logic [31:0] hi);
		case ($urandom_range(0, 9))
			0: return lo;
			1: return hi;
			2: return lo + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
			3: return hi + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
			4: return $urandom();
			default: return ($signed(lo) >>> 1) + ($signed(hi) >>> 1)
				+ $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
		endcase
	endfunction

	task automatic random_rays(int count);
		ray_t r;
		for (int n = 0; n < count; n++) begin
			for (int a = 0; a < 3; a++) begin
				r.pos[a] = rand_coord(box_plane[2*a], box_plane[2*a+1]);
				r.dir[a] = rand_dir();
			end
			send_ray(r, 1'b0, '0);
		end
	endtask

	initial begin
		logic [31:0] c;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = bsir_pkg::RegXLow;
		cfg_data = '0;
		mismatches = 0;
		no_idle = 1'b0;
		for (int i = 0; i < 6; i++)
			box_plane[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Box still at its reset value: every plane through the origin.
		add_row(0, 0, 0, 0, 0, 0, 1'b1, 1'b1, 1'b0, 0);
		add_row(32'h0001_0000, 0, 0, DirOne, 0, 0, 1'b1, 1'b0, 1'b0, 0);
		add_row(32'hFFFF_0000, 0, 0, DirOne, 0, 0, 1'b1, 1'b0, 1'b1, 32'h0001_0000);
		// Saturated distance, and a distance that truncates to zero.
		add_row(32'h8000_0000, 0, 0, 32'h1, 0, 0, 1'b1, 1'b0, 1'b1, DistSat);
		add_row(32'hFFFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 0, 1'b1, 1'b0, 1'b0, 0);
		add_row(0, 0, 32'h7FFF_FFFF, 0, 0, -DirOne, 1'b1, 1'b0, 1'b1, 32'h7FFF_FFFF);
		add_row(0, 32'h0002_0000, 0, 0, -DirOne, 0, 1'b1, 1'b0, 1'b1, 32'h0002_0000);
		add_row(0, 0, 0, 32'h8000_0000, 32'hFFFF_FFFF, DirOne, 1'b1, 1'b1, 1'b0, 0);
		// Against a unit box: ties between axes, points on planes, mixed signs.
		add_row(0, 0, 0, DirOne, DirOne, -DirOne, 1'b0, 0, 0, 0);
		add_row(32'h0001_0000, 32'hFFFF_0000, 0, -DirOne, DirOne, 0, 1'b0, 0, 0, 0);
		add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000, 1, -1, 32'h2000_0000,
			1'b0, 0, 0, 0);
		add_row(32'h0000_4000, 32'hFFFF_C000, 32'h0001_0001, 32'hC000_0000,
			32'h1000_0000, 32'h7FFF_FFFF, 1'b0, 0, 0, 0);
		add_row(32'hFFFE_0000, 32'h0002_0000, 32'hFFFF_0000, DirOne, -DirOne, DirOne,
			1'b0, 0, 0, 0);
		foreach (ray_rows[i]) begin
			if (i == 8) begin
				write_box(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000,
					32'hFFFF_0000, 32'h0001_0000);
				// Spare indexes must leave the box alone.
				write_reg(RegSpare6, 32'h1234_5678);
				write_reg(RegSpare7, 32'hFFFF_FFFF);
			end
			send_ray(ray_rows[i].ray, ray_rows[i].typed, ray_rows[i].res);
		end

		// Random phases over several box settings, one of them with no idling.
		no_idle = 1'b1;
		random_rays(280);
		no_idle = 1'b0;
		write_box(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF, 32'h0000_0001);
		random_rays(280);
		// Low planes above high ones: nothing is inside.
		write_box(32'h0005_0000, 32'hFFFB_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h0000_0010, 32'h0000_0008);
		random_rays(280);
		write_box($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
		random_rays(280);
		c = $urandom();
		write_box(c - 32'h0000_8000, c + 32'h0000_8000, c - 32'h0002_0000,
			c + 32'h0002_0000, c - 1, c + 1);
		random_rays(280);
		write_box(32'hFFF0_0000, 32'h0010_0000, 32'hFFF0_0000, 32'h0010_0000,
			32'hFFF0_0000, 32'h0010_0000);
		random_rays(280);

		drain();
		repeat (DrainCycles) @(negedge clk);
		if (mismatches == 0 && pending_res.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/bsir_pkg.sv
sv/box_surface_inside_and_ray_distance_unit.sv
dv/box_surface_inside_and_ray_distance_unit_tb.sv
